// ===== rtl/display_copper_coprocessor_assert.svh =====
// ----------------------------------------------------------------------------
// Display copper coprocessor assertion macros
// Shared assertion shorthands; each expects clock and reset in the module.
// ----------------------------------------------------------------------------
`ifndef DISPLAY_COPPER_COPROCESSOR_ASSERT_SVH
`define DISPLAY_COPPER_COPROCESSOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DCC_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DCC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Display copper coprocessor package
// Field widths, request codes, and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package dcc_pkg;

   // Default sizes for the top-level parameters.
   localparam int MEM_BYTES_DEF  = 2048;
   localparam int STEP_LIMIT_DEF = 64;

   // At most this many MOVE results are emitted for one raster line.
   localparam int MAX_RESULTS = 64;
   localparam int MOVE_CNT_W  = $clog2(MAX_RESULTS + 1);

   // Field widths.
   localparam int OP_W     = 3;
   localparam int DATA_W   = 8;
   localparam int LINE_W   = 9;
   localparam int INDEX_W  = 11;
   localparam int PC_W     = 10;
   localparam int MODE_W   = 2;
   localparam int REG_NUM_W = 7;

   // Request codes.
   localparam logic [OP_W-1:0] OP_DATA      = 3'd0;
   localparam logic [OP_W-1:0] OP_INDEX_LO  = 3'd1;
   localparam logic [OP_W-1:0] OP_CONTROL   = 3'd2;
   localparam logic [OP_W-1:0] OP_PAIR      = 3'd3;
   localparam logic [OP_W-1:0] OP_LINE      = 3'd4;
   localparam logic [OP_W-1:0] OP_FRAME_END = 3'd5;

   // Run modes.
   localparam logic [MODE_W-1:0] MODE_STOP  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FRAME = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic write_op;    // Apply a bus write or frame-end request.
      logic start_line;  // Begin running a raster line.
      logic fetch;       // Read the instruction at the program counter.
      logic exec;        // Commit the fetched instruction.
      logic flush;       // Line done: release the held MOVE as the last one.
   } dcc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic line_runs;   // The offered raster line would execute.
      logic is_move;     // The fetched instruction is a MOVE.
      logic wait_miss;   // The fetched instruction is an unsatisfied WAIT.
      logic out_free;    // The result register can take a transfer this cycle.
      logic held_valid;  // A MOVE is held back awaiting its last flag.
   } dcc_status_type;

endpackage

// ===== rtl/dcc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module dcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array and read register.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/dcc_datapath.sv =====
// ----------------------------------------------------------------------------
// Display copper coprocessor datapath
// Program memory banks, bus-write registers, instruction decode, held MOVE
// and the result register.
// ----------------------------------------------------------------------------
module dcc_datapath import dcc_pkg::*; #(
   parameter int MEM_BYTES = MEM_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [OP_W-1:0]      req_op,
   input  logic [DATA_W-1:0]    req_data,
   input  logic [LINE_W-1:0]    req_raster_line,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [REG_NUM_W-1:0] rsp_reg_number,
   output logic [DATA_W-1:0]    rsp_reg_value,
   output logic                 rsp_last,
   input  dcc_cmd_type          cmd,
   output dcc_status_type       status
);

   // Even bytes (instruction high halves) and odd bytes live in separate banks.
   localparam int BANK_DEPTH = MEM_BYTES / 2;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);

   logic [INDEX_W-1:0]   write_index_ff, write_index_in;
   logic [PC_W-1:0]      pc_ff, pc_in;
   logic [MODE_W-1:0]    run_mode_ff, run_mode_in;
   logic                 waiting_ff, waiting_in;
   logic [LINE_W-1:0]    awaited_ff, awaited_in;
   logic                 pair_pending_ff, pair_pending_in;
   logic [DATA_W-1:0]    pair_high_ff, pair_high_in;
   logic [LINE_W-1:0]    line_ff, line_in;
   logic                 held_valid_ff, held_valid_in;
   logic [REG_NUM_W-1:0] held_number_ff, held_number_in;
   logic [DATA_W-1:0]    held_value_ff, held_value_in;
   logic                 out_valid_ff, out_valid_in;
   logic [REG_NUM_W-1:0] out_number_ff, out_number_in;
   logic [DATA_W-1:0]    out_value_ff, out_value_in;
   logic                 out_last_ff, out_last_in;

   logic                 out_load;
   logic                 out_free;
   logic [MODE_W-1:0]    mode_new;
   logic                 even_we, odd_we;
   logic [DATA_W-1:0]    even_wd;
   logic [BANK_AW-1:0]   wr_addr;
   logic [BANK_AW-1:0]   rd_addr;
   logic [DATA_W-1:0]    instr_hi, instr_lo;
   logic [LINE_W-1:0]    wait_line;
   logic                 is_wait, is_move, wait_miss;

   // Writes address both banks by the index without its byte-select bit; reads use the program counter.
   assign wr_addr = BANK_AW'(write_index_ff[INDEX_W-1:1]);
   assign rd_addr = BANK_AW'(pc_ff);
   assign mode_new = req_data[DATA_W-1:DATA_W-MODE_W];

   dcc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (BANK_DEPTH)
   ) u_even_bank (
      .clock   (clock),
      .wr_en   (even_we),
      .wr_addr (wr_addr),
      .wr_data (even_wd),
      .rd_en   (cmd.fetch),
      .rd_addr (rd_addr),
      .rd_data (instr_hi)
   );

   dcc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (BANK_DEPTH)
   ) u_odd_bank (
      .clock   (clock),
      .wr_en   (odd_we),
      .wr_addr (wr_addr),
      .wr_data (req_data),
      .rd_en   (cmd.fetch),
      .rd_addr (rd_addr),
      .rd_data (instr_lo)
   );

   // Instruction decode: WAIT has the top bit set, an all-zero word is a NOOP.
   assign is_wait   = instr_hi[DATA_W-1];
   assign wait_line = {instr_hi[0], instr_lo};
   assign wait_miss = is_wait && (wait_line != line_ff);
   assign is_move   = !is_wait && ((instr_hi | instr_lo) != '0);
   assign out_free  = !out_valid_ff || !rsp_stall;

   assign status.line_runs  = (run_mode_ff != MODE_STOP) &&
                              (!waiting_ff || (awaited_ff == req_raster_line));
   assign status.is_move    = is_move;
   assign status.wait_miss  = wait_miss;
   assign status.out_free   = out_free;
   assign status.held_valid = held_valid_ff;

   // Next-state logic for the register file, the held MOVE and the result.
   always_comb begin
      write_index_in  = write_index_ff;
      pc_in           = pc_ff;
      run_mode_in     = run_mode_ff;
      waiting_in      = waiting_ff;
      awaited_in      = awaited_ff;
      pair_pending_in = pair_pending_ff;
      pair_high_in    = pair_high_ff;
      line_in         = line_ff;
      held_valid_in   = held_valid_ff;
      held_number_in  = held_number_ff;
      held_value_in   = held_value_ff;
      out_number_in   = out_number_ff;
      out_value_in    = out_value_ff;
      out_last_in     = out_last_ff;
      out_load        = 1'b0;
      even_we         = 1'b0;
      odd_we          = 1'b0;
      even_wd         = req_data;

      // Bus writes and frame-end events.
      if (cmd.write_op) begin
         case (req_op)
            OP_DATA: begin
               if (write_index_ff[0]) begin
                  odd_we = 1'b1;
               end else begin
                  even_we = 1'b1;
               end
               write_index_in = INDEX_W'(write_index_ff + 1'b1);
            end
            OP_INDEX_LO: begin
               write_index_in = {write_index_ff[INDEX_W-1:8], req_data};
            end
            OP_CONTROL: begin
               write_index_in = {req_data[INDEX_W-9:0], write_index_ff[7:0]};
               if ((mode_new != run_mode_ff) && (mode_new != MODE_STOP)) begin
                  pc_in      = '0;
                  waiting_in = 1'b0;
               end
               run_mode_in = mode_new;
            end
            OP_PAIR: begin
               if (!pair_pending_ff) begin
                  pair_high_in    = req_data;
                  pair_pending_in = 1'b1;
               end else begin
                  even_we         = 1'b1;
                  odd_we          = 1'b1;
                  even_wd         = pair_high_ff;
                  write_index_in  = INDEX_W'(write_index_ff + 2'd2);
                  pair_pending_in = 1'b0;
               end
            end
            OP_FRAME_END: begin
               if (run_mode_ff == MODE_FRAME) begin
                  pc_in      = '0;
                  waiting_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      // A raster line that runs clears any satisfied wait.
      if (cmd.start_line) begin
         line_in    = req_raster_line;
         waiting_in = 1'b0;
      end

      // Commit one instruction; a new MOVE pushes the previous one out.
      if (cmd.exec) begin
         pc_in = PC_W'(pc_ff + 1'b1);
         if (wait_miss) begin
            waiting_in = 1'b1;
            awaited_in = wait_line;
         end
         if (is_move) begin
            if (held_valid_ff) begin
               out_load    = 1'b1;
               out_last_in = 1'b0;
            end
            held_valid_in  = 1'b1;
            held_number_in = instr_hi[REG_NUM_W-1:0];
            held_value_in  = instr_lo;
         end
      end

      // End of line: the held MOVE goes out marked as the last one.
      if (cmd.flush && held_valid_ff) begin
         out_load      = 1'b1;
         out_last_in   = 1'b1;
         held_valid_in = 1'b0;
      end

      // Result register: cleared by a transfer, refilled from the held MOVE.
      out_valid_in = out_valid_ff && rsp_stall;
      if (out_load) begin
         out_valid_in  = 1'b1;
         out_number_in = held_number_ff;
         out_value_in  = held_value_ff;
      end
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         write_index_ff  <= '0;
         pc_ff           <= '0;
         run_mode_ff     <= MODE_STOP;
         waiting_ff      <= 1'b0;
         awaited_ff      <= '0;
         pair_pending_ff <= 1'b0;
         pair_high_ff    <= '0;
         held_valid_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         write_index_ff  <= write_index_in;
         pc_ff           <= pc_in;
         run_mode_ff     <= run_mode_in;
         waiting_ff      <= waiting_in;
         awaited_ff      <= awaited_in;
         pair_pending_ff <= pair_pending_in;
         pair_high_ff    <= pair_high_in;
         held_valid_ff   <= held_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      line_ff        <= line_in;
      held_number_ff <= held_number_in;
      held_value_ff  <= held_value_in;
      out_number_ff  <= out_number_in;
      out_value_ff   <= out_value_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_reg_number = out_number_ff;
   assign rsp_reg_value  = out_value_ff;
   assign rsp_last       = out_last_ff;

`include "display_copper_coprocessor_assert.svh"

   // A result is never loaded over one that is still stalled.
   `DCC_ASSERT_IMPLIES(a_no_result_overwrite, out_load, out_free, "result register overwritten")

endmodule

// ===== rtl/dcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Display copper coprocessor controller
// Sequences request intake, instruction fetch and execute, and line flush.
// ----------------------------------------------------------------------------
module dcc_ctrl import dcc_pkg::*; #(
   parameter int STEP_LIMIT = STEP_LIMIT_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_op,
   output logic            req_stall,
   input  dcc_status_type  status,
   output dcc_cmd_type     cmd
);

   localparam int STEP_W = $clog2(STEP_LIMIT + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_EXEC,
      S_FLUSH
   } state_type;

   state_type             state_ff, state_in;
   logic [STEP_W-1:0]     step_cnt_ff, step_cnt_in;
   logic [MOVE_CNT_W-1:0] move_cnt_ff, move_cnt_in;

   logic accept;
   logic exec_block;
   logic step_done;
   logic move_done;

   // Requests are taken only between lines.
   assign req_stall  = (state_ff != S_IDLE);
   assign accept     = req_valid && !req_stall;

   // A second MOVE cannot commit until the previous one can leave.
   assign exec_block = status.is_move && status.held_valid && !status.out_free;
   assign step_done  = (step_cnt_ff == STEP_W'(STEP_LIMIT - 1));
   assign move_done  = status.is_move && (move_cnt_ff == MOVE_CNT_W'(MAX_RESULTS - 1));

   // Commands and next state.
   always_comb begin
      cmd.write_op   = accept && (req_op != OP_LINE);
      cmd.start_line = accept && (req_op == OP_LINE) && status.line_runs;
      cmd.fetch      = (state_ff == S_FETCH);
      cmd.exec       = (state_ff == S_EXEC) && !exec_block;
      cmd.flush      = (state_ff == S_FLUSH) && (status.out_free || !status.held_valid);

      state_in    = state_ff;
      step_cnt_in = step_cnt_ff;
      move_cnt_in = move_cnt_ff;

      case (state_ff)
         S_IDLE: begin
            if (cmd.start_line) begin
               state_in    = S_FETCH;
               step_cnt_in = '0;
               move_cnt_in = '0;
            end
         end
         S_FETCH: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (cmd.exec) begin
               step_cnt_in = STEP_W'(step_cnt_ff + 1'b1);
               if (status.is_move) begin
                  move_cnt_in = MOVE_CNT_W'(move_cnt_ff + 1'b1);
               end
               if (status.wait_miss || step_done || move_done) begin
                  state_in = S_FLUSH;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_FLUSH: begin
            if (cmd.flush) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         step_cnt_ff <= '0;
         move_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         step_cnt_ff <= step_cnt_in;
         move_cnt_ff <= move_cnt_in;
      end
   end

`include "display_copper_coprocessor_assert.svh"

   // The line budget is never overrun.
   `DCC_ASSERT_IMPLIES(a_step_bound, state_ff == S_EXEC, step_cnt_ff < STEP_W'(STEP_LIMIT), "step budget overrun")
   // The result limit is never overrun.
   `DCC_ASSERT_IMPLIES(a_move_bound, state_ff == S_EXEC, move_cnt_ff < MOVE_CNT_W'(MAX_RESULTS), "result limit overrun")
   // Between lines no MOVE is left behind in the datapath.
   `DCC_ASSERT_IMPLIES(a_idle_drained, state_ff == S_IDLE, !status.held_valid, "held MOVE left at line end")
   // Every line starts its budget afresh.
   `DCC_ASSERT_NEXT(a_line_fresh, cmd.start_line, (step_cnt_ff == '0) && (move_cnt_ff == '0), "counters not cleared")

endmodule

// ===== rtl/display_copper_coprocessor.sv =====
// Raster-synchronized MOVE/WAIT display coprocessor. Bus writes (data byte,
// index low, control, paired data) and frame-end events are applied when
// accepted. A raster line request runs the program: each of at most
// STEP_LIMIT instructions is a program memory read followed by decode and
// commit, and the line ends with a flush; a MOVE commit stalls while the
// previous MOVE waits to leave on a stalled result side. One MOVE is held
// back internally so that the last one of a line can carry its last flag.
// Program memory is split into even and odd byte banks so that a whole
// 16-bit instruction is read in one access and a byte pair is written in
// one access; it needs no clearing pass after reset, and MEM_BYTES must be
// a power of two.
// ----------------------------------------------------------------------------
// Display copper coprocessor top level
// Joins the sequencing controller and the program datapath.
// ----------------------------------------------------------------------------
module display_copper_coprocessor import dcc_pkg::*; #(
   parameter int MEM_BYTES  = MEM_BYTES_DEF,
   parameter int STEP_LIMIT = STEP_LIMIT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OP_W-1:0]      req_op,
   input  logic [DATA_W-1:0]    req_data,
   input  logic [LINE_W-1:0]    req_raster_line,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [REG_NUM_W-1:0] rsp_reg_number,
   output logic [DATA_W-1:0]    rsp_reg_value,
   output logic                 rsp_last
);

   dcc_cmd_type    cmd;
   dcc_status_type status;

   // Sequencer.
   dcc_ctrl #(
      .STEP_LIMIT (STEP_LIMIT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Program memory, registers and result stage.
   dcc_datapath #(
      .MEM_BYTES (MEM_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_op          (req_op),
      .req_data        (req_data),
      .req_raster_line (req_raster_line),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_reg_number  (rsp_reg_number),
      .rsp_reg_value   (rsp_reg_value),
      .rsp_last        (rsp_last),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Display copper coprocessor testbench
// A directed table followed by random program loads and raster-line runs.
// Every transfer on the request side advances a predictor of the coprocessor.
// Each MOVE transfer on the result side is checked field by field against
// the oldest predicted MOVE. Both sides insert random gaps.
// ----------------------------------------------------------------------------
module tb_top;
   import dcc_pkg::*;

   // Request codes that the block ignores.
   localparam logic [OP_W-1:0] OP_UNUSED6 = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED7 = 3'd7;

   // Marks a directed row whose results come from the predictor alone.
   localparam logic [6:0] BY_MODEL = 7'h7F;

   localparam int ITEM_TARGET = 300;
   localparam int IDLE_LIMIT  = 4000;
   localparam int DRAIN_WAIT  = 300;

   typedef struct packed {
      logic [REG_NUM_W-1:0] num;
      logic [DATA_W-1:0]    val;
      logic                 last_flag;
   } move_t;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [DATA_W-1:0]    data;
      logic [LINE_W-1:0]    line;
      logic [6:0]           want_n;
      logic [REG_NUM_W-1:0] want_num;
      logic [DATA_W-1:0]    want_val;
      logic                 want_last;
   } row_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [OP_W-1:0]      req_op = OP_DATA;
   logic [DATA_W-1:0]    req_data = '0;
   logic [LINE_W-1:0]    req_raster_line = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [REG_NUM_W-1:0] rsp_reg_number;
   logic [DATA_W-1:0]    rsp_reg_value;
   logic                 rsp_last;

   display_copper_coprocessor dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_data(req_data),
      .req_raster_line(req_raster_line),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_reg_number(rsp_reg_number),
      .rsp_reg_value(rsp_reg_value),
      .rsp_last(rsp_last)
   );

   // Predicted coprocessor state.
   logic [7:0]         cop_mem [0:MEM_BYTES_DEF-1];
   bit                 cop_written [0:MEM_BYTES_DEF-1];
   logic [INDEX_W-1:0] cop_index = '0;
   logic [PC_W-1:0]    cop_pc = '0;
   logic [MODE_W-1:0]  cop_mode = MODE_STOP;
   bit                 cop_waiting = 1'b0;
   logic [LINE_W-1:0]  cop_wait_line = '0;
   bit                 cop_pair_open = 1'b0;
   logic [7:0]         cop_pair_hi = '0;

   // MOVEs predicted but not yet seen, and what the latest request produced.
   move_t expected_moves [$];
   int    line_move_count;
   move_t line_first_move;

   int errors = 0;
   int items_sent = 0;
   int burst_left = 0;
   int rsp_hold = 0;
   int rsp_pick;
   int idle_cycles = 0;
   logic [LINE_W-1:0] line_pool [0:3];

   // Directed rows: reset state, ignored codes, a short program, and the
   // wait, fall-through, restart and frame-end cases.
   row_t plan [0:24] = '{
      {OP_LINE,      8'h00, 9'd0,   7'd0,     7'd0,   8'h00, 1'b0},
      {OP_UNUSED6,   8'hFF, 9'd511, 7'd0,     7'd0,   8'h00, 1'b0},
      {OP_UNUSED7,   8'h00, 9'd0,   7'd0,     7'd0,   8'h00, 1'b0},
      {OP_PAIR,      8'h7F, 9'd0,   BY_MODEL, 7'd0,   8'h00, 1'b0},
      {OP_PAIR,      8'hFF, 9'd0,   BY_MODEL, 7'd0,   8'h00, 1'b0},
      {OP_PAIR,      8'h00, 9'd0,   BY_MODEL, 7'd0,   8'h00, 1'b0},
      {OP_PAIR,      8'h00, 9'd0,   BY_MODEL, 7'd0,   8'h00, 1'b0},
      {OP_PAIR,      8'hFE, 9'd0,   BY_MODEL, 7'd0,   8'h00, 1'b0},
      {OP_PAIR,      8'h05, 9'd0,   BY_MODEL, 7'd0,   8'h00, 1'b0},
      {OP_DATA,      8'h00, 9'd0,   BY_MODEL, 7'd0,   8'h00, 1'b0},
      {OP_DATA,      8'h01, 9'd0,   BY_MODEL, 7'd0,   8'h00, 1'b0},
      {OP_PAIR,      8'h81, 9'd0,   BY_MODEL, 7'd0,   8'h00, 1'b0},
      {OP_PAIR,      8'hFF, 9'd0,   BY_MODEL, 7'd0,   8'h00, 1'b0},
      {OP_DATA,      8'h80, 9'd0,   BY_MODEL, 7'd0,   8'h00, 1'b0},
      {OP_DATA,      8'h00, 9'd0,   BY_MODEL, 7'd0,   8'h00, 1'b0},
      {OP_CONTROL,   8'h40, 9'd0,   BY_MODEL, 7'd0,   8'h00, 1'b0},
      {OP_LINE,      8'h00, 9'd0,   7'd1,     7'd127, 8'hFF, 1'b1},
      {OP_LINE,      8'hFF, 9'd4,   7'd0,     7'd0,   8'h00, 1'b0},
      {OP_LINE,      8'h00, 9'd5,   BY_MODEL, 7'd0,   8'h00, 1'b0},
      {OP_LINE,      8'h00, 9'd511, 7'd0,     7'd0,   8'h00, 1'b0},
      {OP_CONTROL,   8'hC0, 9'd0,   BY_MODEL, 7'd0,   8'h00, 1'b0},
      {OP_LINE,      8'h00, 9'd2,   BY_MODEL, 7'd0,   8'h00, 1'b0},
      {OP_FRAME_END, 8'h00, 9'd0,   BY_MODEL, 7'd0,   8'h00, 1'b0},
      {OP_LINE,      8'h00, 9'd5,   BY_MODEL, 7'd0,   8'h00, 1'b0},
      {OP_CONTROL,   8'h07, 9'd0,   BY_MODEL, 7'd0,   8'h00, 1'b0}
   };

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   // Runs one raster line on the predicted state. With commit clear, nothing
   // changes and only blank_read is reported: whether an unwritten program
   // byte would be executed.
   task automatic trace_line(input logic [LINE_W-1:0] ln, input bit commit,
                             output bit blank_read);
      logic [PC_W-1:0]   pc;
      bit                waiting;
      bit                halted;
      logic [LINE_W-1:0] wait_ln;
      logic [7:0]        hi;
      logic [7:0]        lo;
      int                step;
      move_t             found [$];
      pc = cop_pc;
      waiting = cop_waiting;
      wait_ln = cop_wait_line;
      halted = 1'b0;
      blank_read = 1'b0;
      if (cop_mode != MODE_STOP && !(waiting && wait_ln != ln)) begin
         waiting = 1'b0;
         for (step = 0; step < STEP_LIMIT_DEF && found.size() < MAX_RESULTS && !halted;
              step++) begin
            if (!cop_written[{pc, 1'b0}] || !cop_written[{pc, 1'b1}])
               blank_read = 1'b1;
            hi = cop_mem[{pc, 1'b0}];
            lo = cop_mem[{pc, 1'b1}];
            pc = pc + 1'b1;
            if (hi[7]) begin
               // A WAIT on the current line falls through.
               if ({hi[0], lo} != ln) begin
                  waiting = 1'b1;
                  wait_ln = {hi[0], lo};
                  halted = 1'b1;
               end
            end else if ({hi, lo} != 16'h0000) begin
               found.push_back({hi[6:0], lo, 1'b0});
            end
         end
      end
      if (commit) begin
         cop_pc = pc;
         cop_waiting = waiting;
         cop_wait_line = wait_ln;
         line_move_count = found.size();
         if (found.size() > 0) begin
            found[found.size() - 1].last_flag = 1'b1;
            line_first_move = found[0];
         end
         foreach (found[i]) expected_moves.push_back(found[i]);
      end
   endtask

   // Applies one accepted request to the predicted state.
   task automatic copper_predict(input logic [OP_W-1:0] op, input logic [7:0] d,
                                 input logic [LINE_W-1:0] ln);
      bit                 blank;
      logic [INDEX_W-1:0] base;
      line_move_count = 0;
      case (op)
         OP_DATA: begin
            cop_mem[cop_index] = d;
            cop_written[cop_index] = 1'b1;
            cop_index = cop_index + 1'b1;
         end
         OP_INDEX_LO: begin
            cop_index[7:0] = d;
         end
         OP_CONTROL: begin
            cop_index[10:8] = d[2:0];
            if (d[7:6] != cop_mode && d[7:6] != MODE_STOP) begin
               cop_pc = '0;
               cop_waiting = 1'b0;
            end
            cop_mode = d[7:6];
         end
         OP_PAIR: begin
            if (!cop_pair_open) begin
               cop_pair_hi = d;
               cop_pair_open = 1'b1;
            end else begin
               // The pair lands at the even address at or below the index.
               base = {cop_index[10:1], 1'b0};
               cop_mem[base] = cop_pair_hi;
               cop_mem[base + 1'b1] = d;
               cop_written[base] = 1'b1;
               cop_written[base + 1'b1] = 1'b1;
               cop_index = cop_index + 2'd2;
               cop_pair_open = 1'b0;
            end
         end
         OP_LINE: begin
            trace_line(ln, 1'b1, blank);
         end
         OP_FRAME_END: begin
            if (cop_mode == MODE_FRAME) begin
               cop_pc = '0;
               cop_waiting = 1'b0;
            end
         end
         default: begin
         end
      endcase
   endtask

   // Sender gap: mostly none or short, sometimes a long pause, and now and
   // then a stretch of back-to-back transfers.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if (r < 45) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 92) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(10, 40);
   endfunction

   // Presents one request, waits for its transfer, then idles at random.
   task automatic send(input logic [OP_W-1:0] op, input logic [7:0] d,
                       input logic [LINE_W-1:0] ln);
      int gap;
      req_valid <= 1'b1;
      req_op <= op;
      req_data <= d;
      req_raster_line <= ln;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      copper_predict(op, d, ln);
      if (op != OP_UNUSED6 && op != OP_UNUSED7) items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // A raster line is only sent when it cannot execute unwritten memory.
   task automatic send_line(input logic [LINE_W-1:0] ln);
      bit blank;
      logic [7:0] d;
      d = 8'($urandom_range(0, 255));
      trace_line(ln, 1'b0, blank);
      if (!blank) send(OP_LINE, d, ln);
   endtask

   // Drops valid and waits for every predicted MOVE.
   task automatic drain_moves();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_moves.size() != 0) @(posedge clock);
   endtask

   // One instruction, written as a byte pair or as two single bytes.
   task automatic put_word(input logic [7:0] hi, input logic [7:0] lo);
      logic [LINE_W-1:0] noise;
      noise = LINE_W'($urandom_range(0, 511));
      if ($urandom_range(0, 3) != 0) begin
         send(OP_PAIR, hi, noise);
         send(OP_PAIR, lo, noise);
      end else begin
         send(OP_DATA, hi, noise);
         send(OP_DATA, lo, noise);
      end
   endtask

   function automatic logic [LINE_W-1:0] pool_line();
      return line_pool[$urandom_range(0, 3)];
   endfunction

   // Stops the program, loads a fresh one at address zero, starts it in a
   // random mode and feeds it raster lines and frame ends.
   task automatic run_program();
      int                n_instr;
      int                k;
      int                r;
      bit                all_moves;
      logic [LINE_W-1:0] wl;
      logic [7:0]        hi;
      logic [7:0]        lo;
      logic [2:0]        junk;
      logic [MODE_W-1:0] run_mode;
      foreach (line_pool[i]) begin
         r = $urandom_range(0, 7);
         line_pool[i] = (r == 0) ? 9'd0 : (r == 1) ? 9'd511 :
                        LINE_W'($urandom_range(0, 511));
      end
      if (cop_pair_open)
         send(OP_PAIR, 8'($urandom_range(0, 255)), LINE_W'($urandom_range(0, 511)));
      junk = 3'($urandom_range(0, 7));
      send(OP_CONTROL, {MODE_STOP, junk, 3'b000}, LINE_W'($urandom_range(0, 511)));
      send(OP_INDEX_LO, 8'h00, LINE_W'($urandom_range(0, 511)));
      all_moves = ($urandom_range(0, 9) == 0);
      n_instr = all_moves ? int'($urandom_range(64, 70)) : int'($urandom_range(2, 20));
      for (k = 0; k <= n_instr; k++) begin
         r = $urandom_range(0, 9);
         if (k < n_instr && (all_moves || r < 6)) begin
            hi = 8'($urandom_range(0, 127));
            lo = 8'($urandom_range(0, 255));
         end else if (k < n_instr && r < 7) begin
            hi = 8'h00;
            lo = 8'h00;
         end else begin
            // WAIT, with random horizontal bits; the program always ends in one.
            wl = pool_line();
            hi = {1'b1, 6'($urandom_range(0, 63)), wl[8]};
            lo = wl[7:0];
         end
         put_word(hi, lo);
      end
      run_mode = MODE_W'($urandom_range(1, 3));
      junk = 3'($urandom_range(0, 7));
      send(OP_CONTROL, {run_mode, junk, 3'($urandom_range(0, 7))},
           LINE_W'($urandom_range(0, 511)));
      for (k = $urandom_range(3, 12); k > 0; k--) begin
         r = $urandom_range(0, 99);
         if (r < 30 && cop_waiting) send_line(cop_wait_line);
         else if (r < 55) send_line(pool_line());
         else if (r < 75) send_line(LINE_W'($urandom_range(0, 511)));
         else if (r < 88) send(OP_FRAME_END, 8'($urandom_range(0, 255)),
                               LINE_W'($urandom_range(0, 511)));
         else if (r < 95) send(OP_W'($urandom_range(OP_UNUSED6, OP_UNUSED7)),
                               8'($urandom_range(0, 255)),
                               LINE_W'($urandom_range(0, 511)));
         else drain_moves();
      end
   endtask

   // Random requests of every code, lines only where memory is written.
   task automatic send_noise();
      logic [OP_W-1:0] op;
      op = OP_W'($urandom_range(0, 7));
      if (op == OP_LINE) send_line(LINE_W'($urandom_range(0, 511)));
      else send(op, 8'($urandom_range(0, 255)), LINE_W'($urandom_range(0, 511)));
   endtask

   // Result-side stall: short and long stalls, with stretches of none.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_pick = $urandom_range(0, 99);
         if (rsp_pick < 50) begin
            rsp_stall <= 1'b0;
            rsp_hold <= $urandom_range(0, 5);
         end else if (rsp_pick < 88) begin
            rsp_stall <= 1'b1;
            rsp_hold <= $urandom_range(0, 2);
         end else if (rsp_pick < 96) begin
            rsp_stall <= 1'b0;
            rsp_hold <= $urandom_range(20, 60);
         end else begin
            rsp_stall <= 1'b1;
            rsp_hold <= $urandom_range(10, 40);
         end
      end
   end

   // Compares each MOVE transfer with the oldest prediction.
   always @(posedge clock) begin : check_moves
      move_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_moves.size() == 0) begin
            flag_mismatch("unexpected MOVE, reg_number", int'(rsp_reg_number), -1);
         end else begin
            want = expected_moves.pop_front();
            if (rsp_reg_number != want.num)
               flag_mismatch("reg_number", int'(rsp_reg_number), int'(want.num));
            if (rsp_reg_value != want.val)
               flag_mismatch("reg_value", int'(rsp_reg_value), int'(want.val));
            if (rsp_last !== want.last_flag)
               flag_mismatch("last", int'(rsp_last), int'(want.last_flag));
         end
      end
   end

   // Ends the run when no transfer happens on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table; typed rows also pin down the predicted count and first MOVE.
      foreach (plan[i]) begin
         send(plan[i].op, plan[i].data, plan[i].line);
         if (plan[i].want_n != BY_MODEL) begin
            if (line_move_count != plan[i].want_n)
               flag_mismatch($sformatf("row %0d MOVE count", i), line_move_count,
                             int'(plan[i].want_n));
            if (plan[i].want_n > 0 &&
                line_first_move != {plan[i].want_num, plan[i].want_val, plan[i].want_last})
               flag_mismatch($sformatf("row %0d first MOVE", i), int'(line_first_move),
                             int'({plan[i].want_num, plan[i].want_val, plan[i].want_last}));
         end
      end
      drain_moves();

      // Random part: mostly whole programs, some loose requests.
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1, 2: repeat ($urandom_range(1, 6)) send_noise();
            3: drain_moves();
            default: run_program();
         endcase
      end

      drain_moves();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== display_copper_coprocessor.f =====
+incdir+rtl
rtl/dcc_pkg.sv
rtl/dcc_ram.sv
rtl/dcc_datapath.sv
rtl/dcc_ctrl.sv
rtl/display_copper_coprocessor.sv
tb/sv/tb_top.sv
